>>> hdl/fractional_box_resampler_unit_defines.svh
// ---------------------------------------------------------------------------
// fractional_box_resampler_unit_defines.svh
// Assertion macros used by the resampler top level
// ---------------------------------------------------------------------------
`ifndef FRACTIONAL_BOX_RESAMPLER_UNIT_DEFINES_SVH
`define FRACTIONAL_BOX_RESAMPLER_UNIT_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, disabled during reset
`define FBR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define FBR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define FBR_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define FBR_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> hdl/fbr_pkg.sv
// ---------------------------------------------------------------------------
// fbr_pkg
// Shared constants, types and helpers of the fractional box resampler
// ---------------------------------------------------------------------------
package fbr_pkg;

   // default fraction bits of phase, step and sums
   localparam int FRAC_BITS_DEF = 16;

   // fixed sample and quotient widths
   localparam int SAMPLE_W = 16;
   localparam int OUT_W    = 16;
   localparam int QUOT_W   = 16;
   localparam int CNT_W    = $clog2(QUOT_W);

   // configuration port
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_RATIO = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MUTE       = 8'd1;

   // saturation limits
   localparam logic [OUT_W-1:0] SAT_POS = 16'h7fff;
   localparam logic [OUT_W-1:0] SAT_NEG = 16'h8000;

   // divider status toward the sequencer
   typedef struct packed {
      logic             done;
      logic [OUT_W-1:0] quot;
   } fbr_div_status_type;

   // sign-apply and clamp a quotient magnitude
   function automatic logic [OUT_W-1:0] fbr_saturate(input logic neg, input logic big,
                                                     input logic [QUOT_W-1:0] mag);
      logic [OUT_W-1:0] res;
      if (neg) begin
         if (big || (mag > SAT_NEG)) begin
            res = SAT_NEG;
         end else begin
            res = ~mag + 1'b1;
         end
      end else begin
         if (big || mag[QUOT_W-1]) begin
            res = SAT_POS;
         end else begin
            res = mag;
         end
      end
      return res;
   endfunction

endpackage

>>> hdl/fbr_divider.sv
// ---------------------------------------------------------------------------
// fbr_divider
// Iterative signed-by-unsigned restoring divider with 16-bit saturation
// ---------------------------------------------------------------------------
module fbr_divider #(
   parameter int FRAC_BITS = fbr_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [FRAC_BITS+23:0]     numer,
   input  logic        [FRAC_BITS+3:0]      denom,
   output fbr_pkg::fbr_div_status_type      status
);
   import fbr_pkg::*;

   localparam int SUM_W  = FRAC_BITS + 24;
   localparam int STEP_W = FRAC_BITS + 4;
   localparam int REM_W  = STEP_W + QUOT_W;
   localparam int DSH_W  = STEP_W + QUOT_W - 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_ITER
   } div_state_type;

   div_state_type      state_ff;
   logic               done_ff;
   logic [OUT_W-1:0]   quot_out_ff;
   logic               neg_ff;
   logic [SUM_W-1:0]   mag_ff;
   logic [STEP_W-1:0]  den_ff;
   logic [REM_W-1:0]   rem_ff;
   logic [DSH_W-1:0]   dsh_ff;
   logic [QUOT_W-1:0]  quot_ff;
   logic [CNT_W-1:0]   cnt_ff;

   logic [SUM_W-1:0]   numer_mag;
   logic               too_big;
   logic [REM_W-1:0]   trial;
   logic               fits;
   logic [QUOT_W-1:0]  quot_in;

   // magnitude of the numerator
   assign numer_mag = numer[SUM_W-1] ? (~numer + 1'b1) : numer;

   // quotient of 2^16 or more always saturates
   assign too_big = mag_ff >= SUM_W'({den_ff, {QUOT_W{1'b0}}});

   // one restoring step
   assign trial   = rem_ff - REM_W'(dsh_ff);
   assign fits    = rem_ff >= REM_W'(dsh_ff);
   assign quot_in = {quot_ff[QUOT_W-2:0], fits};

   // sequencer and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  neg_ff   <= numer[SUM_W-1];
                  mag_ff   <= numer_mag;
                  den_ff   <= denom;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (too_big) begin
                  quot_out_ff <= fbr_saturate(neg_ff, 1'b1, '0);
                  done_ff     <= 1'b1;
                  state_ff    <= S_IDLE;
               end else begin
                  rem_ff   <= mag_ff[REM_W-1:0];
                  dsh_ff   <= {den_ff, {(QUOT_W-1){1'b0}}};
                  quot_ff  <= '0;
                  cnt_ff   <= CNT_W'(QUOT_W - 1);
                  state_ff <= S_ITER;
               end
            end
            S_ITER: begin
               if (fits) begin
                  rem_ff <= trial;
               end
               quot_ff <= quot_in;
               dsh_ff  <= dsh_ff >> 1;
               cnt_ff  <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  quot_out_ff <= fbr_saturate(neg_ff, 1'b0, quot_in);
                  done_ff     <= 1'b1;
                  state_ff    <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign status.done = done_ff;
   assign status.quot = quot_out_ff;

endmodule

>>> hdl/fractional_box_resampler_unit.sv
// ---------------------------------------------------------------------------
// fractional_box_resampler_unit
// Stereo box-filter downsampler by a fractional Q4.F step ratio
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | tdata: left_in, right_in
//  rsp     | out       | rsp_tvalid/tready    | tdata: left_out, right_out
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
//  An item that only accumulates passes through the shared multiplier alone;
//  one that closes an output also makes two passes through the shared divider
//  (range check plus one quotient bit a cycle, or the check alone when it
//  already saturates), and it uses the one shared multiplier as well.
//  Requests are taken only while the sequencer is idle; a finished result
//  sits in the output register while the next request is taken, and the
//  sequencer holds before its output step until that register is free.
//  Synchronous active-high reset clears phase and sums and sets step to 1.0.
// ---------------------------------------------------------------------------
`include "fractional_box_resampler_unit_defines.svh"

module fractional_box_resampler_unit #(
   parameter int FRAC_BITS = fbr_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // fields from bit 0 up: left_in[15:0], right_in[15:0]
   input  logic [31:0]                        req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // fields from bit 0 up: left_out[15:0], right_out[15:0]
   output logic [31:0]                        rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fbr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fbr_pkg::CSR_DATA_W-1:0]     csr_data
);
   import fbr_pkg::*;

   localparam int STEP_W = FRAC_BITS + 4;
   localparam int SUM_W  = FRAC_BITS + 24;
   localparam int WGT_W  = FRAC_BITS + 1;
   localparam int PROD_W = SAMPLE_W + WGT_W + 1;
   localparam logic [STEP_W-1:0] ONE_STEP = STEP_W'(1) << FRAC_BITS;
   localparam logic [WGT_W-1:0]  ONE_WGT  = WGT_W'(1) << FRAC_BITS;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_L,
      ST_MUL_R,
      ST_ACC_R,
      ST_DIV_L,
      ST_DIV_R,
      ST_LOAD_L,
      ST_LOAD_R,
      ST_LOAD_D,
      ST_EMIT
   } seq_state_type;

   seq_state_type               state_ff;
   logic [STEP_W-1:0]           step_ratio_ff;
   logic                        mute_ff;
   logic [STEP_W-1:0]           phase_ff;
   logic signed [SUM_W-1:0]     sum_l_ff;
   logic signed [SUM_W-1:0]     sum_r_ff;
   logic signed [SAMPLE_W-1:0]  left_ff;
   logic signed [SAMPLE_W-1:0]  right_ff;
   logic [STEP_W-1:0]           step_eff_ff;
   logic                        bypass_ff;
   logic signed [PROD_W-1:0]    prod_ff;
   logic [OUT_W-1:0]            ql_ff;
   logic [OUT_W-1:0]            qr_ff;
   logic                        rsp_tvalid_ff;
   logic [31:0]                 rsp_tdata_ff;

   logic                        req_accept;
   logic [WGT_W-1:0]            first_wgt;
   logic signed [SAMPLE_W-1:0]  mul_sample;
   logic [WGT_W-1:0]            mul_weight;
   logic signed [PROD_W-1:0]    mul_prod;
   logic                        div_start;
   logic signed [SUM_W-1:0]     div_numer;
   fbr_div_status_type          div_status;
   logic                        div_wait;
   logic                        emit_fire;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ratio_ff <= ONE_STEP;
         mute_ff       <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STEP_RATIO: step_ratio_ff <= csr_data[STEP_W-1:0];
            CSR_MUTE:       mute_ff       <= csr_data[0];
            default:        ;
         endcase
      end
   end

   // weight of the part that opens the next output
   assign first_wgt = ONE_WGT - phase_ff[WGT_W-1:0];

   // shared multiplier operand selection
   assign mul_sample = (state_ff == ST_MUL_L || state_ff == ST_LOAD_L) ? left_ff : right_ff;
   assign mul_weight = (state_ff == ST_LOAD_L || state_ff == ST_LOAD_R) ? first_wgt :
                       (bypass_ff ? ONE_WGT : phase_ff[WGT_W-1:0]);
   assign mul_prod   = mul_sample * $signed({1'b0, mul_weight});

   // divider launch: left after accumulation, right when left is done
   assign div_start = (state_ff == ST_ACC_R && !bypass_ff) ||
                      (state_ff == ST_DIV_L && div_status.done);
   assign div_numer = (state_ff == ST_ACC_R) ? sum_l_ff : sum_r_ff;
   assign div_wait  = (state_ff == ST_DIV_L || state_ff == ST_DIV_R);

   // output step fires once the result register is free
   assign emit_fire = (state_ff == ST_EMIT) && (!rsp_tvalid_ff || rsp_tready);

   fbr_divider #(
      .FRAC_BITS (FRAC_BITS)
   ) u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .numer  (div_numer),
      .denom  (step_eff_ff),
      .status (div_status)
   );

   // sequencer, state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= '0;
         sum_l_ff      <= '0;
         sum_r_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // result valid: set by the output step, cleared once taken
         if (emit_fire) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  left_ff     <= mute_ff ? '0 : req_tdata[SAMPLE_W-1:0];
                  right_ff    <= mute_ff ? '0 : req_tdata[2*SAMPLE_W-1:SAMPLE_W];
                  step_eff_ff <= (step_ratio_ff < ONE_STEP) ? ONE_STEP : step_ratio_ff;
                  bypass_ff   <= |phase_ff[STEP_W-1:FRAC_BITS];
                  state_ff    <= ST_MUL_L;
               end
            end
            ST_MUL_L: begin
               prod_ff  <= mul_prod;
               state_ff <= ST_MUL_R;
            end
            ST_MUL_R: begin
               prod_ff  <= mul_prod;
               sum_l_ff <= sum_l_ff + SUM_W'(prod_ff);
               state_ff <= ST_ACC_R;
            end
            ST_ACC_R: begin
               sum_r_ff <= sum_r_ff + SUM_W'(prod_ff);
               if (bypass_ff) begin
                  phase_ff <= phase_ff - ONE_STEP;
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_DIV_L;
               end
            end
            ST_DIV_L: begin
               if (div_status.done) begin
                  ql_ff    <= div_status.quot;
                  state_ff <= ST_DIV_R;
               end
            end
            ST_DIV_R: begin
               if (div_status.done) begin
                  qr_ff    <= div_status.quot;
                  state_ff <= ST_LOAD_L;
               end
            end
            ST_LOAD_L: begin
               prod_ff  <= mul_prod;
               state_ff <= ST_LOAD_R;
            end
            ST_LOAD_R: begin
               prod_ff  <= mul_prod;
               sum_l_ff <= SUM_W'(prod_ff);
               state_ff <= ST_LOAD_D;
            end
            ST_LOAD_D: begin
               sum_r_ff <= SUM_W'(prod_ff);
               phase_ff <= step_eff_ff - STEP_W'(first_wgt);
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (emit_fire) begin
                  rsp_tdata_ff  <= {qr_ff, ql_ff};
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // divider finishes only while the sequencer waits for it
   `FBR_ASSERT_IMPL(a_div_done_waiting, clock, reset, div_status.done, div_wait)
   // an accumulate-only request never reaches the divider
   `FBR_ASSERT_IMPL(a_bypass_no_div, clock, reset, div_wait, !bypass_ff)
   // a new result appears only out of the output step
   `FBR_ASSERT_IMPL(a_rsp_from_emit, clock, reset, $rose(rsp_tvalid_ff), $past(state_ff) == ST_EMIT)

endmodule

>>> sim/fractional_box_resampler_unit_tb.sv
// ---------------------------------------------------------------------------
// fractional_box_resampler_unit_tb
// Self-checking bench for the stereo fractional box resampler
// ---------------------------------------------------------------------------
// Samples are streamed in through the request channel. Each accepted request
// is run through a fixed-point copy of the phase and sum logic, and the
// output pair it predicts is queued. Every pair taken from the response
// channel is checked against the oldest queued pair, field by field. Step
// and mute are rewritten between phases, only while the unit is idle. Steps
// under 1.0, masked upper bits and ignored register indexes are covered too.
// Both sides idle and stall in several patterns, and one long receiver
// hold-off backs the unit up into its input.
// ---------------------------------------------------------------------------
module fractional_box_resampler_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = fbr_pkg::FRAC_BITS_DEF;
   localparam int STEP_W = FRAC + 4;
   localparam longint ONE_Q = longint'(1) << FRAC;

   // register values used by name
   localparam logic [31:0] STEP_ONE      = 32'h0001_0000;
   localparam logic [31:0] STEP_FOUR     = 32'h0004_0000;
   localparam logic [31:0] STEP_ZERO     = 32'h0000_0000;
   localparam logic [31:0] STEP_MAX      = 32'h000f_ffff;
   localparam logic [31:0] STEP_ONE_JUNK = 32'hfff1_0000;
   localparam logic [31:0] ALL_ONES      = 32'hffff_ffff;
   localparam logic [31:0] MUTE_ON       = 32'h0000_0001;
   localparam logic [31:0] MUTE_OFF      = 32'h0000_0000;
   localparam logic [fbr_pkg::CSR_INDEX_W-1:0] CSR_FIRST_UNUSED = fbr_pkg::CSR_MUTE + 1'b1;
   localparam logic [fbr_pkg::CSR_INDEX_W-1:0] CSR_LAST_INDEX   = '1;

   localparam logic [15:0] PCM_MAX = 16'h7fff;
   localparam logic [15:0] PCM_MIN = 16'h8000;

   localparam int SETTLE_CYCLES = 64;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 106;

   // left in the low half, right in the high half
   typedef struct packed {
      logic [15:0] right;
      logic [15:0] left;
   } stereo_pair_type;

   // ------------------------------------------------------------------------
   // phase/sum tracker and queue of predicted output pairs
   // ------------------------------------------------------------------------
   class resampler_tracker_type;
      logic [STEP_W-1:0] step_ratio;
      logic              mute;
      logic [STEP_W-1:0] phase;
      longint            sum_left;
      longint            sum_right;
      stereo_pair_type   pending_outputs[$];
      int                failures;

      function new();
         step_ratio = STEP_ONE[STEP_W-1:0];
         mute       = 1'b0;
         phase      = '0;
         sum_left   = 0;
         sum_right  = 0;
         failures   = 0;
      endfunction

      // register write, out-of-range indexes change nothing
      function void write_reg(input logic [fbr_pkg::CSR_INDEX_W-1:0] index,
                              input logic [fbr_pkg::CSR_DATA_W-1:0] data);
         if (index == fbr_pkg::CSR_STEP_RATIO) begin
            step_ratio = data[STEP_W-1:0];
         end else if (index == fbr_pkg::CSR_MUTE) begin
            mute = data[0];
         end
      endfunction

      // truncating divide, clamped to 16 bits
      function logic [15:0] divide_clamp(input longint sum, input longint step);
         longint q;
         q = sum / step;
         if (q > 32767) q = 32767;
         if (q < -32768) q = -32768;
         return q[15:0];
      endfunction

      // one accepted request, queues a pair when it closes an output period
      function void take_sample(input stereo_pair_type s);
         longint          l;
         longint          r;
         longint          step;
         longint          first;
         stereo_pair_type pair;
         l = longint'($signed(s.left));
         r = longint'($signed(s.right));
         step = (step_ratio < ONE_Q) ? ONE_Q : longint'(step_ratio);
         if (mute) begin
            l = 0;
            r = 0;
         end
         if (phase >= ONE_Q) begin
            phase = phase - ONE_Q[STEP_W-1:0];
            sum_left += l * ONE_Q;
            sum_right += r * ONE_Q;
         end else begin
            sum_left += l * longint'(phase);
            sum_right += r * longint'(phase);
            pair.left = divide_clamp(sum_left, step);
            pair.right = divide_clamp(sum_right, step);
            pending_outputs.push_back(pair);
            first = ONE_Q - longint'(phase);
            sum_left = l * first;
            sum_right = r * first;
            phase = STEP_W'(step - first);
         end
      endfunction

      // compare a response with the oldest predicted pair
      function void compare_output(input stereo_pair_type got);
         stereo_pair_type want;
         if (pending_outputs.size() == 0) begin
            failures++;
            $display("%0t: unexpected response left=%h right=%h",
                     $time, got.left, got.right);
         end else begin
            want = pending_outputs.pop_front();
            if (got.left !== want.left) begin
               failures++;
               $display("%0t: left_out expected %h actual %h", $time, want.left, got.left);
            end
            if (got.right !== want.right) begin
               failures++;
               $display("%0t: right_out expected %h actual %h", $time, want.right, got.right);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic [31:0] req_tdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic        csr_valid;
   logic        csr_ready;
   logic [fbr_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [fbr_pkg::CSR_DATA_W-1:0]  csr_data;

   resampler_tracker_type tracker = new();

   // idling controls: percent of cycles, and a receiver hold-off length
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;

   fractional_box_resampler_unit #(
      .FRAC_BITS(FRAC)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #10ms;
      $display("simulation failed");
      $finish;
   end

   // receiver ready, random stalls plus counted hold-off
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else begin
            rsp_tready = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.compare_output(stereo_pair_type'(rsp_tdata));
      end
   end

   // one sample request, called and left at a falling edge
   task automatic send_sample(input logic [15:0] left, input logic [15:0] right);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata = {right, left};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      tracker.take_sample(stereo_pair_type'(req_tdata));
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // one register write
   task automatic write_csr(input logic [fbr_pkg::CSR_INDEX_W-1:0] index,
                            input logic [fbr_pkg::CSR_DATA_W-1:0] data);
      csr_index = index;
      csr_data = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(index, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // wait for every predicted pair, then for a request that gave none
   task automatic settle();
      while (tracker.pending_outputs.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // sample value weighted toward the rails and near zero
   function automatic logic [15:0] pick_sample();
      logic [15:0] v;
      case ($urandom_range(9))
         0: v = PCM_MAX;
         1: v = PCM_MIN;
         2: v = 16'($urandom_range(32)) - 16'd16;
         default: v = 16'($urandom());
      endcase
      return v;
   endfunction

   // step value, extremes and below-one values included
   function automatic logic [31:0] pick_step();
      logic [31:0] v;
      case ($urandom_range(9))
         0: v = STEP_ONE;
         1: v = STEP_MAX;
         2: v = STEP_ZERO;
         3: v = 32'($urandom_range(STEP_ONE - 1));
         4: v = $urandom();
         5, 6: v = 32'($urandom_range(STEP_FOUR, STEP_ONE));
         default: v = 32'($urandom_range(STEP_MAX, STEP_ONE));
      endcase
      return v;
   endfunction

   // stimulus
   initial begin
      int p;
      int k;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // default step of 1.0, rails and sign mixes
      send_sample(16'h0000, 16'h0000);
      send_sample(PCM_MAX, PCM_MAX);
      send_sample(PCM_MIN, PCM_MIN);
      send_sample(PCM_MAX, PCM_MIN);
      send_sample(PCM_MIN, PCM_MAX);
      send_sample(16'h0001, 16'hffff);
      settle();

      // zero step runs as 1.0
      write_csr(fbr_pkg::CSR_STEP_RATIO, STEP_ZERO);
      send_sample(16'h1234, 16'hedcb);
      send_sample(PCM_MAX, PCM_MIN);
      settle();

      // step 4.0 then back to 1.0 mid-period, sums saturate on both rails
      write_csr(fbr_pkg::CSR_STEP_RATIO, STEP_FOUR);
      repeat (3) send_sample(PCM_MAX, PCM_MIN);
      settle();
      write_csr(fbr_pkg::CSR_STEP_RATIO, STEP_ONE_JUNK);
      repeat (2) send_sample(PCM_MAX, PCM_MIN);
      settle();

      // mute, then writes to unused indexes
      write_csr(fbr_pkg::CSR_MUTE, MUTE_ON);
      send_sample(PCM_MAX, 16'h5a5a);
      send_sample(16'ha5a5, PCM_MIN);
      settle();
      write_csr(CSR_FIRST_UNUSED, ALL_ONES);
      write_csr(CSR_LAST_INDEX, STEP_ZERO);
      write_csr(fbr_pkg::CSR_MUTE, MUTE_OFF);

      // largest step through upper junk bits
      write_csr(fbr_pkg::CSR_STEP_RATIO, ALL_ONES);
      repeat (4) send_sample(pick_sample(), pick_sample());
      settle();

      // long receiver hold-off backs the unit up, then a full drain
      write_csr(fbr_pkg::CSR_STEP_RATIO, STEP_ONE);
      hold_left = 300;
      for (k = 0; k < 24; k++) send_sample(pick_sample(), pick_sample());
      while (tracker.pending_outputs.size() != 0) @(negedge clock);
      settle();

      // random phases, idling pattern rotates
      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
         endcase
         if (p == 0) begin
            write_csr(fbr_pkg::CSR_STEP_RATIO, STEP_ONE);
         end else if (p == 1) begin
            write_csr(fbr_pkg::CSR_STEP_RATIO, STEP_MAX);
         end else begin
            write_csr(fbr_pkg::CSR_STEP_RATIO, pick_step());
         end
         write_csr(fbr_pkg::CSR_MUTE, ($urandom_range(6) == 0) ? $urandom() : MUTE_OFF);
         if ($urandom_range(2) == 0) begin
            write_csr(fbr_pkg::CSR_INDEX_W'($urandom_range(CSR_LAST_INDEX, CSR_FIRST_UNUSED)),
                      $urandom());
         end
         for (k = 0; k < PHASE_ITEMS; k++) send_sample(pick_sample(), pick_sample());
         settle();
      end

      // drain and finish
      while (tracker.pending_outputs.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (tracker.failures == 0 && tracker.pending_outputs.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
